// File: rtl/lcc_pkg.sv
// Shared types, constants and the intensity curve for the LCD color correction block.
`timescale 1ns / 1ps

package lcc_pkg;

    // Number of color channels
    localparam int NumCh = 3;
    // Width of one channel contribution after the mix shift
    localparam int PartW = 7;
    // Right shift applied after the channel-mix multiply
    localparam int MixShift = 5;
    // Offset added to every output channel
    localparam logic [7:0] OutBias = 8'd32;

    // Input request fields
    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pixel_in;

    // Result fields
    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } t_pixel_out;

    // Contributions indexed [output channel][input channel]
    typedef logic [NumCh-1:0][NumCh-1:0][PartW-1:0] t_part_mat;

    // Channel-mix weights indexed [input channel][output channel]
    localparam logic [4:0] MIX [NumCh][NumCh] = '{
        '{5'd16, 5'd4,  5'd4},
        '{5'd8,  5'd16, 5'd8},
        '{5'd0,  5'd8,  5'd16}
    };

    // Fixed 32-entry intensity curve
    function automatic logic [7:0] curve_lut(input logic [4:0] idx);
        logic [7:0] v;
        case (idx)
            5'd0:  v = 8'd0;
            5'd1:  v = 8'd16;
            5'd2:  v = 8'd32;
            5'd3:  v = 8'd48;
            5'd4:  v = 8'd64;
            5'd5:  v = 8'd80;
            5'd6:  v = 8'd94;
            5'd7:  v = 8'd108;
            5'd8:  v = 8'd122;
            5'd9:  v = 8'd136;
            5'd10: v = 8'd148;
            5'd11: v = 8'd160;
            5'd12: v = 8'd174;
            5'd13: v = 8'd183;
            5'd14: v = 8'd191;
            5'd15: v = 8'd198;
            5'd16: v = 8'd206;
            5'd17: v = 8'd211;
            5'd18: v = 8'd217;
            5'd19: v = 8'd223;
            5'd20: v = 8'd227;
            5'd21: v = 8'd231;
            5'd22: v = 8'd235;
            5'd23: v = 8'd239;
            5'd24: v = 8'd243;
            5'd25: v = 8'd246;
            5'd26: v = 8'd249;
            5'd27: v = 8'd251;
            5'd28: v = 8'd253;
            5'd29: v = 8'd254;
            5'd30: v = 8'd255;
            5'd31: v = 8'd255;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/lcc_mix.sv
// Curve lookup and 3x3 channel mix producing the nine channel contributions.
`timescale 1ns / 1ps

module lcc_mix import lcc_pkg::*; (
    input  t_pixel_in i_pixel,
    output t_part_mat o_part
);

    logic [NumCh-1:0][7:0] lvl;
    logic [NumCh-1:0][12:0] prod [NumCh];

    // Look up curve level from the top five bits of each channel
    assign lvl[0] = curve_lut(i_pixel.red_in[7:3]);
    assign lvl[1] = curve_lut(i_pixel.green_in[7:3]);
    assign lvl[2] = curve_lut(i_pixel.blue_in[7:3]);

    // Weight each level and drop the mix fraction bits
    always_comb begin
        for (int c = 0; c < NumCh; c++) begin
            for (int k = 0; k < NumCh; k++) begin
                prod[c][k] = 13'(lvl[c]) * 13'(MIX[c][k]);
                o_part[k][c] = prod[c][k][MixShift +: PartW];
            end
        end
    end

endmodule

// File: rtl/lcc_blend.sv
// Sort the three contributions per output channel and form the weighted blend.
`timescale 1ns / 1ps

module lcc_blend import lcc_pkg::*; (
    input  t_part_mat  i_part,
    output t_pixel_out o_pixel
);

    logic [NumCh-1:0][7:0] res;

    // Sort ascending, then ((low + 2*mid + 4*high) * 5 >> 4) + bias
    function automatic logic [7:0] blend3(input logic [PartW-1:0] a_in,
                                          input logic [PartW-1:0] b_in,
                                          input logic [PartW-1:0] c_in);
        logic [PartW-1:0] a;
        logic [PartW-1:0] b;
        logic [PartW-1:0] c;
        logic [PartW-1:0] t;
        logic [9:0]       sum;
        logic [12:0]      scaled;
        logic [8:0]       q;
        a = a_in;
        b = b_in;
        c = c_in;
        if (a > b) begin
            t = a; a = b; b = t;
        end
        if (b > c) begin
            t = b; b = c; c = t;
        end
        if (a > b) begin
            t = a; a = b; b = t;
        end
        sum    = 10'(a) + {2'b0, b, 1'b0} + {1'b0, c, 2'b0};
        scaled = {sum, 2'b00} + 13'(sum);
        q      = scaled[12:4];
        return 8'(q + 9'(OutBias));
    endfunction

    // Blend each output channel
    always_comb begin
        for (int k = 0; k < NumCh; k++) begin
            res[k] = blend3(i_part[k][0], i_part[k][1], i_part[k][2]);
        end
    end

    assign o_pixel.red_out   = res[0];
    assign o_pixel.green_out = res[1];
    assign o_pixel.blue_out  = res[2];

endmodule

// File: rtl/handheld_lcd_color_correction.sv
// A request is taken into the input register, and its result strobe comes from the result register.
// Throughput: one pixel per clock; busy stays low, so start may be held every cycle.
// The path from input register to result register is a curve lookup, a shift-mix,
// a three-way sort and a small weighted add.
// Reset (synchronous, active low) clears both valid flags; results cannot be stalled.
`timescale 1ns / 1ps

module handheld_lcd_color_correction import lcc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  t_pixel_in  i_pixel,
    output logic       busy,
    output logic       o_valid,
    output t_pixel_out o_pixel
);

    t_pixel_in  r_in;
    logic       r_in_vld;
    t_pixel_out r_out;
    logic       r_out_vld;
    t_part_mat  part;
    t_pixel_out n_out;
    logic       n_in_vld;

    // Always ready for the next request
    assign busy     = 1'b0;
    assign n_in_vld = start && !busy;

    // Hold control flags under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= r_in_vld;
        end
    end

    // Capture request and result payloads
    always_ff @(posedge i_clk) begin
        if (n_in_vld) begin
            r_in <= i_pixel;
        end
        if (r_in_vld) begin
            r_out <= n_out;
        end
    end

    lcc_mix u_mix (
        .i_pixel (r_in),
        .o_part  (part)
    );

    lcc_blend u_blend (
        .i_part  (part),
        .o_pixel (n_out)
    );

    assign o_valid = r_out_vld;
    assign o_pixel = r_out;

endmodule

// File: rtl/lcc_checker.sv
// Port-level checker for the LCD color correction block, bound to the top level.
`timescale 1ns / 1ps

module lcc_port_checker import lcc_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input t_pixel_in  i_pixel,
    input logic       busy,
    input logic       o_valid,
    input t_pixel_out o_pixel
);

    // Never refuse a request
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    // Every request yields a result
    a_req_to_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("result strobe missing");

    // No result without an earlier request
    a_res_from_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 2))
        else $error("unexpected result strobe");

    // Results stay within the biased output range
    a_res_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pixel.red_out >= 8'd32 && o_pixel.red_out <= 8'd239 &&
                     o_pixel.green_out >= 8'd32 && o_pixel.green_out <= 8'd239 &&
                     o_pixel.blue_out >= 8'd32 && o_pixel.blue_out <= 8'd239))
        else $error("result out of range");

endmodule

bind handheld_lcd_color_correction lcc_port_checker u_lcc_port_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .i_pixel (i_pixel),
    .busy    (busy),
    .o_valid (o_valid),
    .o_pixel (o_pixel)
);

// File: bench/lcc_checker.sv
// Checker for the LCD color correction block: predicts each corrected pixel and compares.
`timescale 1ns / 1ps

module lcc_checker import lcc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_busy,
    input  t_pixel_in  i_pixel,
    input  logic       i_valid,
    input  t_pixel_out i_result,
    input  logic       i_end_check,
    output int         o_mismatches,
    output int         o_pending,
    output int         o_pixels_in,
    output int         o_results_out
);

    // Panel intensity response, indexed by the top five bits of a channel
    localparam logic [7:0] LcdCurve [32] = '{
        8'd0,   8'd16,  8'd32,  8'd48,  8'd64,  8'd80,  8'd94,  8'd108,
        8'd122, 8'd136, 8'd148, 8'd160, 8'd174, 8'd183, 8'd191, 8'd198,
        8'd206, 8'd211, 8'd217, 8'd223, 8'd227, 8'd231, 8'd235, 8'd239,
        8'd243, 8'd246, 8'd249, 8'd251, 8'd253, 8'd254, 8'd255, 8'd255
    };

    // Cross-talk weights, [source channel][target channel]
    localparam logic [4:0] BleedWeight [3][3] = '{
        '{5'd16, 5'd4,  5'd4},
        '{5'd8,  5'd16, 5'd8},
        '{5'd0,  5'd8,  5'd16}
    };

    localparam string ChanName [3] = '{"red_out", "green_out", "blue_out"};

    t_pixel_out corrected_q [$];
    bit         end_checked;

    // Sort three contributions and blend them, weighting the strongest most
    function automatic logic [7:0] blend_sorted(input logic [6:0] a, input logic [6:0] b,
                                                input logic [6:0] c);
        logic [6:0]  lo;
        logic [6:0]  md;
        logic [6:0]  hi;
        logic [6:0]  t;
        logic [12:0] wsum;
        lo = a;
        md = b;
        hi = c;
        if (lo > md) begin
            t = lo; lo = md; md = t;
        end
        if (md > hi) begin
            t = md; md = hi; hi = t;
        end
        if (lo > md) begin
            t = lo; lo = md; md = t;
        end
        wsum = 13'(lo) + (13'(md) << 1) + (13'(hi) << 2);
        wsum = wsum * 13'd5;
        return 8'((wsum >> 4) + 13'd32);
    endfunction

    // Expected panel output for one source pixel
    function automatic t_pixel_out lcd_correct(input t_pixel_in px);
        logic [7:0]  lvl [3];
        logic [6:0]  part [3][3];
        logic [15:0] prod;
        logic [7:0]  res [3];
        t_pixel_out  r;
        lvl[0] = LcdCurve[px.red_in[7:3]];
        lvl[1] = LcdCurve[px.green_in[7:3]];
        lvl[2] = LcdCurve[px.blue_in[7:3]];
        for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 3; k++) begin
                prod = 16'(lvl[c]) * 16'(BleedWeight[c][k]);
                part[c][k] = 7'(prod >> 5);
            end
        end
        for (int k = 0; k < 3; k++) begin
            res[k] = blend_sorted(part[0][k], part[1][k], part[2][k]);
        end
        r.red_out   = res[0];
        r.green_out = res[1];
        r.blue_out  = res[2];
        return r;
    endfunction

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string msg);
        o_mismatches++;
        $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    // Pop and compare each result, push a prediction for each accepted request
    always @(posedge i_clk) begin
        t_pixel_out exp_px;
        if (!i_rst_n) begin
            corrected_q.delete();
            end_checked   = 1'b0;
            o_mismatches  = 0;
            o_pixels_in   = 0;
            o_results_out = 0;
            o_pending    <= 0;
        end else begin
            if (i_valid) begin
                o_results_out++;
                if (corrected_q.size() == 0) begin
                    report_mismatch($sformatf("result %0h with no request outstanding",
                                              i_result));
                end else begin
                    exp_px = corrected_q.pop_front();
                    for (int k = 0; k < 3; k++) begin
                        if (i_result[23-8*k -: 8] !== exp_px[23-8*k -: 8]) begin
                            report_mismatch($sformatf("%s got %0d expected %0d",
                                ChanName[k], i_result[23-8*k -: 8], exp_px[23-8*k -: 8]));
                        end
                    end
                end
            end
            if (i_start && !i_busy) begin
                corrected_q.push_back(lcd_correct(i_pixel));
                o_pixels_in++;
            end
            if (i_end_check && !end_checked) begin
                end_checked = 1'b1;
                if (corrected_q.size() != 0) begin
                    report_mismatch($sformatf("%0d results never arrived", corrected_q.size()));
                end
            end
            o_pending <= corrected_q.size();
        end
    end

endmodule

// File: bench/tb_top.sv
// Top of the LCD color correction bench: clock, reset, pixel stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_top;
    import lcc_pkg::*;

    localparam int IdleLimit = 2000;
    localparam int RandPixels = 500;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    t_pixel_in  i_pixel = '0;
    logic       busy;
    logic       o_valid;
    t_pixel_out o_pixel;
    logic       end_check = 1'b0;
    int         mismatches;
    int         pending;
    int         pixels_in;
    int         results_out;
    int         idle_cycles = 0;

    // Extremes, single channels, ignored low bits and curve steps
    t_pixel_in  directed_px [19] = '{
        24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
        24'h070707, 24'hF8F8F8, 24'hF0F0F0, 24'h080808, 24'h101010,
        24'hFFFF00, 24'hFF00FF, 24'h00FFFF, 24'h7F7F7F, 24'h808080,
        24'h874F2B, 24'h5E5E5E, 24'h55AA55, 24'hAA55AA
    };

    always #6 i_clk = ~i_clk;

    handheld_lcd_color_correction uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_pixel (i_pixel),
        .busy    (busy),
        .o_valid (o_valid),
        .o_pixel (o_pixel)
    );

    lcc_checker u_pixel_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_pixel       (i_pixel),
        .i_valid       (o_valid),
        .i_result      (o_pixel),
        .i_end_check   (end_check),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_pixels_in   (pixels_in),
        .o_results_out (results_out)
    );

    // Drive one request and hold it until accepted
    task automatic send_pixel(input t_pixel_in px);
        start   <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (busy);
    endtask

    // Bias channels toward the ends of the byte range
    function automatic logic [7:0] rand_channel();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Abort when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("Timeout: no request or result for %0d cycles", IdleLimit);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int burst_left;
        int gap;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pixels back to back
        foreach (directed_px[i]) begin
            send_pixel(directed_px[i]);
        end

        // Random pixels in bursts with random gaps
        burst_left = $urandom_range(1, 24);
        for (int n = 0; n < RandPixels; n++) begin
            send_pixel({rand_channel(), rand_channel(), rand_channel()});
            burst_left--;
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12)
                                                  : $urandom_range(1, 3);
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                         : $urandom_range(1, 16);
            end
        end
        start <= 1'b0;

        // Drain outstanding results, then let the pipeline settle
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        end_check <= 1'b1;
        repeat (2) @(posedge i_clk);

        $display("Sent %0d pixels (directed corner values, then random bursts and gaps),",
                 pixels_in);
        $display("checked %0d corrected results channel by channel.", results_out);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/lcc_pkg.sv
rtl/lcc_mix.sv
rtl/lcc_blend.sv
rtl/handheld_lcd_color_correction.sv
rtl/lcc_checker.sv
bench/lcc_checker.sv
bench/tb_top.sv
